@@ hw/rtl/cpc_pkg.sv @@
// Package with the types, codes and status bit constants of the card punch controller.
package cpc_pkg;

  localparam int unsigned DefColumns = 80;
  localparam int unsigned WordW      = 18;
  localparam int unsigned CodeW      = 12;
  localparam int unsigned IdxW       = 7;

  typedef enum logic [2:0] {
    OP_STATUS_RD = 3'd0,
    OP_CTRL_WR   = 3'd1,
    OP_DATA_RD   = 3'd2,
    OP_DATA_WR   = 3'd3,
    OP_TICK      = 3'd4,
    OP_COL_RD    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    OUTCOME_OK    = 2'd0,
    OUTCOME_PICK  = 2'd1,
    OUTCOME_EJECT = 2'd2
  } outcome_e;

  // Status word bits.
  localparam logic [WordW-1:0] StLevel     = 18'o0000007;
  localparam logic [WordW-1:0] StDataReq   = 18'o0000010;
  localparam logic [WordW-1:0] StPunchOn   = 18'o0000040;
  localparam logic [WordW-1:0] StEndCard   = 18'o0000100;
  localparam logic [WordW-1:0] StEndEn     = 18'o0000200;
  localparam logic [WordW-1:0] StInPunch   = 18'o0000400;
  localparam logic [WordW-1:0] StError     = 18'o0001000;
  localparam logic [WordW-1:0] StTroubleEn = 18'o0002000;
  localparam logic [WordW-1:0] StTrouble   = 18'o0004000;
  localparam logic [WordW-1:0] StEjectFail = 18'o0010000;
  localparam logic [WordW-1:0] StPickFail  = 18'o0020000;

  // Control write bits.
  localparam logic [WordW-1:0] CwSetReq   = 18'o0000010;
  localparam logic [WordW-1:0] CwClrReq   = 18'o0000020;
  localparam logic [WordW-1:0] CwPunchOn  = 18'o0000040;
  localparam logic [WordW-1:0] CwClrEnd   = 18'o0000100;
  localparam logic [WordW-1:0] CwEnEnd    = 18'o0000200;
  localparam logic [WordW-1:0] CwDisEnd   = 18'o0000400;
  localparam logic [WordW-1:0] CwEnTrb    = 18'o0002000;
  localparam logic [WordW-1:0] CwDisTrb   = 18'o0004000;
  localparam logic [WordW-1:0] CwEject    = 18'o0010000;
  localparam logic [WordW-1:0] CwClrPunch = 18'o0100000;

  localparam logic [WordW-1:0] CodeMask = 18'h00fff;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] write_data;
    logic [IdxW-1:0]  column_index;
    logic [1:0]       punch_outcome;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic             irq_raise;
    logic             irq_clear;
    logic [2:0]       irq_level;
    logic             card_done;
    logic             write_dropped;
  } out_t;

endpackage

@@ hw/rtl/cpc_colbuf.sv @@
// Column buffer: synchronous punch code memory with per-entry valid bits cleared by reset.
module cpc_colbuf #(
  parameter int unsigned COLUMNS = cpc_pkg::DefColumns,
  parameter int unsigned AW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [cpc_pkg::CodeW-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [cpc_pkg::CodeW-1:0] rd_data_o
);
  import cpc_pkg::*;

  logic [CodeW-1:0] mem [COLUMNS];
  logic [COLUMNS-1:0] valid_q;
  logic [CodeW-1:0] rdata_q;
  logic rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

@@ hw/rtl/card_punch_controller.sv @@
// Card punch controller top level: status logic, column counter and result pipeline.
//
//   channel | direction | handshake               | payload
//   in      | to block  | in_valid_i / in_stall_o | in_data_i  (cpc_pkg::in_t)
//   out     | from block| out_valid_o / out_stall_i | out_data_o (cpc_pkg::out_t)
//
// One item per cycle while the output is not stalled. A result passes through the first stage,
// which holds the status update and the column buffer read, and then the output register.
// The status word, column count and pending flag update in the transfer cycle itself.
// Reset clears all control state and marks every buffer column as zero; no clearing pass.
// A stalled output holds both stages; input stall follows once the first stage is full.
module card_punch_controller #(
  parameter int unsigned COLUMNS = cpc_pkg::DefColumns
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cpc_pkg::out_t  out_data_o
);
  import cpc_pkg::*;

  localparam int unsigned AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CW = $clog2(COLUMNS + 1);
  localparam logic [CW-1:0] ColFull = CW'(COLUMNS);

  logic [WordW-1:0] status_q, status_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pending_q, pending_d;

  logic s1_valid_q, out_valid_q;
  out_t s1_q, s1_d, out_q;
  out_t s1_out;
  logic s1_col_q, s1_col_d;

  logic in_xfer, s1_move;
  logic wr_en, rd_en;
  logic [CodeW-1:0] rd_code;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign wr_en = in_xfer && (in_data_i.op == OP_DATA_WR) && (count_q < ColFull);
  assign rd_en = in_xfer && (in_data_i.op == OP_COL_RD);

  cpc_colbuf #(
    .COLUMNS(COLUMNS),
    .AW     (AW)
  ) u_colbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[AW-1:0]),
    .wr_data_i(in_data_i.write_data[CodeW-1:0]),
    .rd_en_i  (rd_en),
    .rd_addr_i(in_data_i.column_index[AW-1:0]),
    .rd_data_o(rd_code)
  );

  always_comb begin
    logic [WordW-1:0] st;
    logic [WordW-1:0] wd;
    st        = status_q;
    wd        = in_data_i.write_data;
    count_d   = count_q;
    pending_d = pending_q;
    s1_d      = '0;
    s1_col_d  = 1'b0;

    unique case (in_data_i.op)
      OP_STATUS_RD: begin
        s1_d.read_data = status_q;
      end
      OP_CTRL_WR: begin
        s1_d.irq_clear = 1'b1;
        st = (st & ~StLevel) | (wd & StLevel);
        if ((wd & CwClrPunch) != '0) begin
          st = st & ~(StTrouble | StError | StEndCard | StEndEn | StTroubleEn);
        end else begin
          if ((wd & CwSetReq) != '0) begin
            st = st | StDataReq;
            s1_d.irq_raise = 1'b1;
          end
          if ((wd & CwClrReq) != '0) st = st & ~StDataReq;
          if ((wd & CwClrEnd) != '0) st = st & ~StEndCard;
          if ((wd & CwEnEnd) != '0)  st = st | StEndEn;
          if ((wd & CwDisEnd) != '0) st = st & ~StEndEn;
          if ((wd & CwEnTrb) != '0)  st = st | StTroubleEn;
          if ((wd & CwDisTrb) != '0) st = st & ~StTroubleEn;
          if (((wd & CwEject) != '0) && ((st & StInPunch) != '0)) begin
            count_d   = ColFull;
            st        = st & ~StDataReq;
            pending_d = 1'b1;
          end
          if ((st & (StTrouble | StTroubleEn)) == (StTrouble | StTroubleEn)) begin
            s1_d.irq_raise = 1'b1;
          end
          if ((st & (StEndCard | StEndEn)) == (StEndCard | StEndEn)) begin
            s1_d.irq_raise = 1'b1;
          end
          if ((wd & CwPunchOn) != '0) begin
            st        = st | StPunchOn;
            pending_d = 1'b1;
          end
        end
      end
      OP_DATA_RD: begin
        s1_d.read_data = '0;
      end
      OP_DATA_WR: begin
        if (count_q < ColFull) begin
          count_d = count_q + 1'b1;
        end else begin
          s1_d.write_dropped = 1'b1;
        end
        st             = st & ~StDataReq;
        s1_d.irq_clear = 1'b1;
        pending_d      = 1'b1;
      end
      OP_TICK: begin
        if (pending_q) begin
          if ((st & StPunchOn) == '0) begin
            pending_d = 1'b0;
          end else begin
            st = st | StInPunch;
            if ((st & StDataReq) != '0) begin
              // Still waiting for the host to supply the requested column.
            end else if (count_q < ColFull) begin
              st             = st | StDataReq;
              s1_d.irq_raise = 1'b1;
            end else begin
              // The buffer is full: the card is finished.
              count_d = '0;
              st      = (st & ~(StPunchOn | StInPunch)) | StEndCard;
              case (in_data_i.punch_outcome)
                OUTCOME_PICK:  st = st | StPickFail | StTrouble;
                OUTCOME_EJECT: st = st | StEjectFail | StTrouble;
                default:       st = st;
              endcase
              if ((st & (StTrouble | StTroubleEn)) == (StTrouble | StTroubleEn)) begin
                s1_d.irq_raise = 1'b1;
              end
              if ((st & StEndEn) != '0) s1_d.irq_raise = 1'b1;
              s1_d.card_done = 1'b1;
              pending_d      = 1'b0;
            end
          end
        end
      end
      OP_COL_RD: begin
        s1_col_d = (in_data_i.column_index < COLUMNS);
      end
      default: begin
      end
    endcase

    status_d       = st;
    s1_d.irq_level = st[2:0];
  end

  // The buffer read data stays put while the first stage holds, so it is merged here.
  always_comb begin
    s1_out = s1_q;
    if (s1_col_q) begin
      s1_out.read_data = {{(WordW - CodeW){1'b0}}, rd_code};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= '0;
      count_q     <= '0;
      pending_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        status_q  <= status_d;
        count_q   <= count_d;
        pending_q <= pending_d;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q     <= s1_d;
      s1_col_q <= s1_col_d;
    end
    if (s1_move) begin
      out_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/cpc_checker.sv @@
// Port-level checker for the card punch controller and its bind statement.
module cpc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input cpc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cpc_pkg::out_t out_data_o
);
  import cpc_pkg::*;

  // A result waiting on a stalled output is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Neither the status word nor a column code ever sets the top bits.
  a_rd_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.read_data[17:14] == 4'd0)
    else $error("read data has bits above the status word set");

  // Finishing a card comes only from a tick, which never withdraws or drops anything.
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.card_done |->
      !out_data_o.irq_clear && !out_data_o.write_dropped && !out_data_o.irq_raise ||
      out_valid_o && out_data_o.card_done && !out_data_o.irq_clear &&
      !out_data_o.write_dropped)
    else $error("card end result carries data write flags");

  // A dropped data write still withdraws the request and reads zero.
  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_dropped |->
      out_data_o.irq_clear && !out_data_o.irq_raise && out_data_o.read_data == '0)
    else $error("dropped write result is malformed");

  // An empty pipeline never holds off the input.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind card_punch_controller cpc_checker u_cpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the card punch controller: a directed table, then random card runs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpc_pkg::*;

  localparam int unsigned Columns   = DefColumns;
  localparam int unsigned DirRows   = 26;
  localparam int unsigned RandOps   = 1150;
  localparam int unsigned TailOps   = 150;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldOff   = 60;
  localparam int unsigned DrainWait = 8;
  localparam int unsigned IdleLimit = 1000;

  typedef struct packed {
    in_t  stim;
    logic chk;
    out_t want;
  } op_row_t;

  localparam out_t Predicted = '0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  op_row_t     bus_ops[$];
  out_t        replies_due[$];
  int unsigned n_taken      = 0;
  int unsigned n_bad        = 0;
  int unsigned quiet_cycles = 0;
  bit          tail_phase   = 1'b0;
  bit          sent_all     = 1'b0;

  // Shadow copy of the controller state.
  logic [WordW-1:0] st_word = '0;
  int unsigned      col_count = 0;
  logic [CodeW-1:0] col_codes [Columns] = '{default: '0};
  bit               svc_pending = 1'b0;

  card_punch_controller #(.COLUMNS(Columns)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin : reset_seq
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic in_t op_item(op_e op, logic [WordW-1:0] wd, logic [IdxW-1:0] idx,
                                  logic [1:0] oc);
    in_t x;
    x.op            = op;
    x.write_data    = wd;
    x.column_index  = idx;
    x.punch_outcome = oc;
    return x;
  endfunction

  function automatic in_t rnd_op(op_e op);
    in_t x;
    x.op            = op;
    x.write_data    = WordW'($urandom);
    x.column_index  = IdxW'($urandom);
    x.punch_outcome = 2'($urandom);
    return x;
  endfunction

  function automatic out_t reply(logic [WordW-1:0] rd, logic clr, logic [2:0] lvl);
    out_t r;
    r           = '0;
    r.read_data = rd;
    r.irq_clear = clr;
    r.irq_level = lvl;
    return r;
  endfunction

  task automatic queue_op(in_t x);
    op_row_t r;
    r.stim = x;
    r.chk  = 1'b0;
    r.want = Predicted;
    bus_ops.push_back(r);
  endtask

  function automatic bit st_all(logic [WordW-1:0] m);
    return (st_word & m) == m;
  endfunction

  // Applies one transfer to the shadow state and returns the reply it should produce.
  function automatic out_t advance_punch(in_t x);
    out_t             r;
    logic [WordW-1:0] wd;
    r  = '0;
    wd = x.write_data;
    case (x.op)
      OP_STATUS_RD: r.read_data = st_word;
      OP_CTRL_WR: begin
        r.irq_clear = 1'b1;
        st_word = (st_word & ~StLevel) | (wd & StLevel);
        if (|(wd & CwClrPunch)) begin
          st_word &= ~(StTrouble | StError | StEndCard | StEndEn | StTroubleEn);
        end else begin
          if (|(wd & CwSetReq)) begin
            st_word |= StDataReq;
            r.irq_raise = 1'b1;
          end
          if (|(wd & CwClrReq)) st_word &= ~StDataReq;
          if (|(wd & CwClrEnd)) st_word &= ~StEndCard;
          if (|(wd & CwEnEnd)) st_word |= StEndEn;
          if (|(wd & CwDisEnd)) st_word &= ~StEndEn;
          if (|(wd & CwEnTrb)) st_word |= StTroubleEn;
          if (|(wd & CwDisTrb)) st_word &= ~StTroubleEn;
          if ((|(wd & CwEject)) && (|(st_word & StInPunch))) begin
            col_count   = Columns;
            st_word    &= ~StDataReq;
            svc_pending = 1'b1;
          end
          if (st_all(StTrouble | StTroubleEn) || st_all(StEndCard | StEndEn)) begin
            r.irq_raise = 1'b1;
          end
          if (|(wd & CwPunchOn)) begin
            st_word    |= StPunchOn;
            svc_pending = 1'b1;
          end
        end
      end
      OP_DATA_WR: begin
        if (col_count < Columns) begin
          col_codes[col_count] = wd[CodeW-1:0];
          col_count++;
        end else begin
          r.write_dropped = 1'b1;
        end
        st_word    &= ~StDataReq;
        r.irq_clear = 1'b1;
        svc_pending = 1'b1;
      end
      OP_TICK: begin
        if (svc_pending) begin
          if (!(|(st_word & StPunchOn))) begin
            svc_pending = 1'b0;
          end else begin
            st_word |= StInPunch;
            // With data request still up the mechanism keeps waiting for the column.
            if (!(|(st_word & StDataReq))) begin
              if (col_count < Columns) begin
                st_word    |= StDataReq;
                r.irq_raise = 1'b1;
              end else begin
                col_count = 0;
                st_word  &= ~(StPunchOn | StInPunch);
                st_word  |= StEndCard;
                if (x.punch_outcome == OUTCOME_PICK) begin
                  st_word |= StPickFail | StTrouble;
                end else if (x.punch_outcome == OUTCOME_EJECT) begin
                  st_word |= StEjectFail | StTrouble;
                end
                if (st_all(StTrouble | StTroubleEn) || (|(st_word & StEndEn))) begin
                  r.irq_raise = 1'b1;
                end
                r.card_done = 1'b1;
                svc_pending = 1'b0;
              end
            end
          end
        end
      end
      OP_COL_RD: begin
        if (x.column_index < Columns) r.read_data = WordW'(col_codes[x.column_index]);
      end
      default: ;
    endcase
    r.irq_level = st_word[2:0];
    return r;
  endfunction

  task automatic diff(string name, logic [WordW-1:0] exp_v, logic [WordW-1:0] got);
    if (got !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got);
      n_bad++;
    end
  endtask

  initial begin : drive_ops
    op_row_t          dir_rows [DirRows];
    in_t              x;
    logic [WordW-1:0] mode;
    int unsigned      n_cols;
    int unsigned      pick;

    dir_rows = '{
      '{op_item(OP_STATUS_RD, '0, 7'd0, OUTCOME_OK), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(OP_DATA_RD, '1, 7'd79, OUTCOME_OK), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(OP_COL_RD, '0, 7'd0, OUTCOME_OK), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(OP_COL_RD, '1, 7'd127, 2'd3), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(OP_TICK, '1, 7'd0, OUTCOME_PICK), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(op_e'(3'd6), '1, 7'd127, 2'd3), 1'b1, reply('0, 1'b0, 3'd0)},
      '{op_item(OP_CTRL_WR, '1, 7'd0, OUTCOME_OK), 1'b1, reply('0, 1'b1, 3'd7)},
      '{op_item(OP_STATUS_RD, '0, 7'd0, OUTCOME_OK), 1'b1, reply(18'd7, 1'b0, 3'd7)},
      '{op_item(OP_CTRL_WR, CwEnEnd | CwEnTrb | CwPunchOn | 18'd5, 7'd0, OUTCOME_OK),
        1'b0, Predicted},
      '{op_item(OP_TICK, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_DATA_WR, '1, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_COL_RD, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwSetReq | CwClrReq | CwEnEnd | CwEnTrb | 18'd5, 7'd0,
        OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwEject | CwEnEnd | CwEnTrb | 18'd5, 7'd0, OUTCOME_OK),
        1'b0, Predicted},
      '{op_item(OP_DATA_WR, 18'h00555, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_TICK, '0, 7'd0, OUTCOME_PICK), 1'b0, Predicted},
      '{op_item(OP_STATUS_RD, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwClrEnd | CwEnEnd | CwDisEnd | CwEnTrb | CwDisTrb, 7'd0,
        OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwClrPunch | 18'd2, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_DATA_WR, 18'h00abc, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_TICK, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwPunchOn | CwEnTrb | 18'd3, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_TICK, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_CTRL_WR, CwEject | CwEnTrb | 18'd3, 7'd0, OUTCOME_OK), 1'b0, Predicted},
      '{op_item(OP_TICK, '0, 7'd0, OUTCOME_EJECT), 1'b0, Predicted},
      '{op_item(OP_STATUS_RD, '0, 7'd0, OUTCOME_OK), 1'b0, Predicted}
    };
    foreach (dir_rows[k]) bus_ops.push_back(dir_rows[k]);

    // Cards with random content, most of them ejected after 1 to 12 columns, mixed with bursts of arbitrary accesses.
    while (bus_ops.size() < DirRows + RandOps) begin
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 6)) queue_op(rnd_op(op_e'(3'($urandom))));
      end else begin
        mode = WordW'($urandom) & ~(CwClrPunch | CwEject | CwPunchOn | CwDisEnd | CwDisTrb);
        if ($urandom_range(0, 7) == 0) mode |= CwDisEnd;
        if ($urandom_range(0, 7) == 0) mode |= CwDisTrb;
        x = rnd_op(OP_CTRL_WR);
        x.write_data = mode | CwPunchOn;
        queue_op(x);
        pick = $urandom_range(0, 19);
        if (pick < 14) n_cols = $urandom_range(1, 12);
        else if (pick < 17) n_cols = $urandom_range(13, Columns - 1);
        else n_cols = Columns;
        for (int c = 0; c < n_cols; c++) begin
          queue_op(rnd_op(OP_TICK));
          queue_op(rnd_op(OP_DATA_WR));
          if ($urandom_range(0, 11) == 0) begin
            x = rnd_op(OP_COL_RD);
            x.column_index = IdxW'($urandom_range(0, Columns - 1));
            queue_op(x);
          end
          if ($urandom_range(0, 15) == 0) queue_op(rnd_op(op_e'(3'($urandom))));
        end
        if (n_cols < Columns) begin
          x = rnd_op(OP_CTRL_WR);
          x.write_data = (mode & ~CwSetReq) | CwEject;
          queue_op(x);
        end
        if ($urandom_range(0, 3) == 0) queue_op(rnd_op(OP_DATA_WR));
        queue_op(rnd_op(OP_TICK));
        queue_op(rnd_op(OP_STATUS_RD));
        if ($urandom_range(0, 1) == 0) begin
          x = rnd_op(OP_CTRL_WR);
          x.write_data = WordW'($urandom_range(0, 7)) |
                         ($urandom_range(0, 1) ? CwClrPunch : CwClrEnd);
          queue_op(x);
        end
      end
    end

    while (rst_ni !== 1'b1) @(posedge clk_i);
    foreach (bus_ops[k]) begin
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= bus_ops[k].stim;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin : drive_stall
    bit held;
    held = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (!held && n_taken >= HoldAt) begin
        // Long hold-off so the pipeline fills and the input side backs up.
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOff) @(posedge clk_i);
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : take_in
    out_t guess;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      guess = advance_punch(in_data_i);
      replies_due.push_back(bus_ops[n_taken].chk ? bus_ops[n_taken].want : guess);
      n_taken++;
      tail_phase = (n_taken + TailOps >= bus_ops.size());
    end
  end

  always @(posedge clk_i) begin : take_out
    out_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        $display("%0t ns: unexpected transfer, expected none, got %0h", $time, out_data_o);
        n_bad++;
      end else begin
        due = replies_due.pop_front();
        diff("read_data", due.read_data, out_data_o.read_data);
        diff("irq_raise", WordW'(due.irq_raise), WordW'(out_data_o.irq_raise));
        diff("irq_clear", WordW'(due.irq_clear), WordW'(out_data_o.irq_clear));
        diff("irq_level", WordW'(due.irq_level), WordW'(out_data_o.irq_level));
        diff("card_done", WordW'(due.card_done), WordW'(out_data_o.card_done));
        diff("write_dropped", WordW'(due.write_dropped), WordW'(out_data_o.write_dropped));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IdleLimit);
        $display("status: fail");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin : finish_run
    while (!sent_all) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ card_punch_controller.f @@
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_colbuf.sv
hw/rtl/card_punch_controller.sv
hw/rtl/cpc_checker.sv
bench/tb_top.sv
